// File: sv/dsrr_pkg.sv
// shared constants, status codes and types of the decimal scale reduction block
`default_nettype none

package dsrr_pkg;

    // scale limits and word counts
    localparam int MAX_SCALE  = 28;
    localparam int WIDE_WORDS = 7;
    localparam int WORD_BITS  = 32;

    // field widths
    localparam int WIDE_BITS      = 224;
    localparam int NARROW_BITS    = 96;
    localparam int LO_BITS        = 64;
    localparam int HI_BITS        = NARROW_BITS - LO_BITS;
    localparam int W0_BITS        = 64;
    localparam int W3_BITS        = 32;
    localparam int SCALE_IN_BITS  = 8;
    localparam int SCALE_OUT_BITS = 5;
    localparam int STATUS_BITS    = 2;

    // words at WIDE_WORDS and above are ignored
    localparam logic [WIDE_BITS-1:0] WIDE_MASK =
        {WIDE_BITS{1'b1}} >> (WIDE_BITS - WORD_BITS * WIDE_WORDS);

    // chunk-serial divide by ten
    localparam int CHUNK_BITS  = 16;
    localparam int N_CHUNKS    = WIDE_BITS / CHUNK_BITS;
    localparam int CNT_BITS    = $clog2(N_CHUNKS);
    localparam int REM_BITS    = 4;
    localparam int X_BITS      = CHUNK_BITS + REM_BITS;
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP_BITS  = 24;
    // ceil(2^27 / 10), exact quotient for any 20-bit dividend
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10);
    localparam int PROD_BITS   = X_BITS + RECIP_BITS;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_POS_OVF = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FAIL    = 2'd2;

    // divider status towards the sequencer
    typedef struct packed {
        logic                done;
        logic [REM_BITS-1:0] rem;
    } t_div_status;

endpackage

`default_nettype wire

// File: sv/dsrr_if.sv
// handshake channels for the input and result transfers
`default_nettype none

interface dsrr_in_if;
    logic                                valid;
    logic                                ready;
    logic [dsrr_pkg::W0_BITS-1:0]        wide_w0;
    logic [dsrr_pkg::W0_BITS-1:0]        wide_w1;
    logic [dsrr_pkg::W0_BITS-1:0]        wide_w2;
    logic [dsrr_pkg::W3_BITS-1:0]        wide_w3;
    logic [dsrr_pkg::SCALE_IN_BITS-1:0]  scale_in;
    logic                                sign_in;

    modport source (output valid, wide_w0, wide_w1, wide_w2, wide_w3, scale_in, sign_in,
                    input ready);
    modport sink   (input valid, wide_w0, wide_w1, wide_w2, wide_w3, scale_in, sign_in,
                    output ready);
endinterface

interface dsrr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [dsrr_pkg::LO_BITS-1:0]         narrow_lo;
    logic [dsrr_pkg::HI_BITS-1:0]         narrow_hi;
    logic [dsrr_pkg::SCALE_OUT_BITS-1:0]  scale_out;
    logic                                 sign_out;
    logic [dsrr_pkg::STATUS_BITS-1:0]     status;

    modport source (output valid, narrow_lo, narrow_hi, scale_out, sign_out, status,
                    input ready);
    modport sink   (input valid, narrow_lo, narrow_hi, scale_out, sign_out, status,
                    output ready);
endinterface

`default_nettype wire

// File: sv/dsrr_div10.sv
// chunk-serial divide by ten of the wide mantissa, most significant chunk first
`default_nettype none

module dsrr_div10 (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [dsrr_pkg::WIDE_BITS-1:0] i_w,
    output      logic [dsrr_pkg::WIDE_BITS-1:0] o_q,
    output      dsrr_pkg::t_div_status          o_status
);

    logic                                r_busy;
    logic                                r_done;
    logic [dsrr_pkg::CNT_BITS-1:0]       r_cnt;
    logic [dsrr_pkg::REM_BITS-1:0]       r_rem;
    logic [dsrr_pkg::WIDE_BITS-1:0]      r_q;

    logic [dsrr_pkg::X_BITS-1:0]         x;
    logic [dsrr_pkg::PROD_BITS-1:0]      prod;
    logic [dsrr_pkg::CHUNK_BITS-1:0]     q_chunk;
    logic [dsrr_pkg::X_BITS-1:0]         q_x10;
    logic [dsrr_pkg::X_BITS-1:0]         rem_full;

    // one digit step: previous remainder joined with the next chunk
    always_comb begin
        x        = {r_rem, i_w[r_cnt * dsrr_pkg::CHUNK_BITS +: dsrr_pkg::CHUNK_BITS]};
        prod     = dsrr_pkg::PROD_BITS'(x) * dsrr_pkg::PROD_BITS'(dsrr_pkg::RECIP);
        q_chunk  = prod[dsrr_pkg::RECIP_SHIFT +: dsrr_pkg::CHUNK_BITS];
        q_x10    = (dsrr_pkg::X_BITS'(q_chunk) << 3) + (dsrr_pkg::X_BITS'(q_chunk) << 1);
        rem_full = x - q_x10;
    end

    // control: count chunks down to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= dsrr_pkg::CNT_BITS'(dsrr_pkg::N_CHUNKS - 1);
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= rem_full[dsrr_pkg::REM_BITS-1:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // quotient chunks shift in from the bottom
    always_ff @(posedge i_clk) begin
        if (r_busy && !i_start) begin
            r_q <= {r_q[dsrr_pkg::WIDE_BITS-dsrr_pkg::CHUNK_BITS-1:0], q_chunk};
        end
    end

    assign o_q           = r_q;
    assign o_status.done = r_done;
    assign o_status.rem  = r_rem;

endmodule

`default_nettype wire

// File: sv/decimal_scale_reduce_round.sv
// top level: decimal scale reduction with round-half-even on the dropped digit
//
//  channel | dir | handshake         | payload
//  i_in    | in  | valid/ready       | wide_w0..wide_w3, scale_in, sign_in
//  o_out   | out | valid/ready       | narrow_lo, narrow_hi, scale_out, sign_out, status
//
//  one item runs n + 1 divider passes, n the number of divide-by-ten steps (0..255)
//  each step is one pass of the 16-bit chunk divider plus a divider start and a loop decision
//  i_in.ready is high only while no item is in work
//  the result register holds one result; a stalled o_out keeps the next result waiting
//  reset is synchronous and active low; no clearing pass is needed
`default_nettype none

module decimal_scale_reduce_round (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dsrr_in_if.sink    i_in,
    dsrr_out_if.source o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                                r_state;
    logic                                  r_start;
    logic                                  r_first;
    logic [dsrr_pkg::WIDE_BITS-1:0]        r_w;
    logic [dsrr_pkg::SCALE_IN_BITS-1:0]    r_scale;
    logic                                  r_sign;

    // finished result waiting for the output register
    logic [dsrr_pkg::NARROW_BITS-1:0]      r_res_m;
    logic [dsrr_pkg::SCALE_OUT_BITS-1:0]   r_res_scale;
    logic                                  r_res_sign;
    logic [dsrr_pkg::STATUS_BITS-1:0]      r_res_status;

    // output register
    logic                                  r_o_valid;
    logic [dsrr_pkg::NARROW_BITS-1:0]      r_o_m;
    logic [dsrr_pkg::SCALE_OUT_BITS-1:0]   r_o_scale;
    logic                                  r_o_sign;
    logic [dsrr_pkg::STATUS_BITS-1:0]      r_o_status;

    logic [dsrr_pkg::WIDE_BITS-1:0]        div_q;
    dsrr_pkg::t_div_status                 div_sts;

    logic                                  in_xfer;
    logic                                  out_free;
    logic                                  too_wide;
    logic                                  is_zero;
    logic                                  scale_pos;
    logic                                  scale_over;
    logic                                  again;
    logic                                  go_on;
    logic                                  round_up;
    logic [dsrr_pkg::WIDE_BITS-1:0]        n_w;
    logic [dsrr_pkg::WIDE_BITS-1:0]        in_w;

    // divide-by-ten unit for the working mantissa
    dsrr_div10 u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_w      (r_w),
        .o_q      (div_q),
        .o_status (div_sts)
    );

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_o_valid || o_out.ready;

    // input mantissa with unused words cleared
    assign in_w = {i_in.wide_w3, i_in.wide_w2, i_in.wide_w1, i_in.wide_w0} & dsrr_pkg::WIDE_MASK;

    // loop decision on the current mantissa and its last digit
    always_comb begin
        too_wide   = |r_w[dsrr_pkg::WIDE_BITS-1:dsrr_pkg::NARROW_BITS];
        is_zero    = ~|r_w;
        scale_pos  = (r_scale != '0);
        scale_over = (r_scale > dsrr_pkg::SCALE_IN_BITS'(dsrr_pkg::MAX_SCALE));
        if (!r_first && scale_over && is_zero) begin
            again = 1'b0;
        end else begin
            again = too_wide || ((div_sts.rem == '0) && scale_pos) || scale_over;
        end
        go_on    = again && scale_pos;
        round_up = (div_sts.rem > dsrr_pkg::REM_BITS'(5))
                   || ((div_sts.rem == dsrr_pkg::REM_BITS'(5)) && div_q[0]);
        n_w      = div_q + dsrr_pkg::WIDE_BITS'(round_up);
    end

    // sequencer, working registers and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= 1'b0;
            r_first   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // output register fills from the waiting result or empties on a transfer
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_start <= in_xfer;
                    if (in_xfer) begin
                        r_w     <= in_w;
                        r_scale <= i_in.scale_in;
                        r_sign  <= i_in.sign_in;
                        r_first <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_start <= div_sts.done && go_on;
                    if (div_sts.done) begin
                        if (go_on) begin
                            r_w     <= n_w;
                            r_scale <= r_scale - 1'b1;
                            r_first <= 1'b0;
                        end else begin
                            if (!too_wide && !scale_over) begin
                                r_res_m      <= r_w[dsrr_pkg::NARROW_BITS-1:0];
                                r_res_scale  <= r_scale[dsrr_pkg::SCALE_OUT_BITS-1:0];
                                r_res_sign   <= r_sign;
                                r_res_status <= dsrr_pkg::STATUS_OK;
                            end else begin
                                r_res_m      <= '0;
                                r_res_scale  <= '0;
                                r_res_sign   <= 1'b0;
                                r_res_status <= (!scale_pos && too_wide && !r_sign)
                                                ? dsrr_pkg::STATUS_POS_OVF
                                                : dsrr_pkg::STATUS_FAIL;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_start <= 1'b0;
                    if (out_free) begin
                        r_o_m      <= r_res_m;
                        r_o_scale  <= r_res_scale;
                        r_o_sign   <= r_res_sign;
                        r_o_status <= r_res_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_start <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_o_valid;
    assign o_out.narrow_lo = r_o_m[dsrr_pkg::LO_BITS-1:0];
    assign o_out.narrow_hi = r_o_m[dsrr_pkg::NARROW_BITS-1:dsrr_pkg::LO_BITS];
    assign o_out.scale_out = r_o_scale;
    assign o_out.sign_out  = r_o_sign;
    assign o_out.status    = r_o_status;

    // failed result carries no mantissa, scale or sign
    a_fail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != dsrr_pkg::STATUS_OK)
        |-> (o_out.narrow_lo == '0 && o_out.narrow_hi == '0
             && o_out.scale_out == '0 && !o_out.sign_out))
        else $error("failed result with non-zero payload");

    // scale never grows while an item is in work
    a_scale_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && $past(r_state) == S_DIV) |-> (r_scale <= $past(r_scale)))
        else $error("scale increased during reduction");

    // a divider pass ends only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == S_DIV))
        else $error("divider finished outside a reduction");

    // the divider is only started for an item in work
    a_start_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == S_DIV))
        else $error("divider started while idle");

    // a good result keeps its scale within the limit
    a_ok_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == dsrr_pkg::STATUS_OK)
        |-> (o_out.scale_out <= dsrr_pkg::SCALE_OUT_BITS'(dsrr_pkg::MAX_SCALE)))
        else $error("result scale above limit");

endmodule

`default_nettype wire
